// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)

`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/r2p_pkg.sv -----
package r2p_pkg;

    // sample and result fields
    localparam int DATA_W    = 16;
    localparam int MAG_W     = 16;
    localparam int PHASE_W   = 16;
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = MAG_W + PHASE_W;

    // square root datapath
    localparam int SQ2_W      = 2 * DATA_W;
    localparam int SQ_W       = 2 * DATA_W + 1;
    localparam int ROOT_STEPS = DATA_W;

    // CORDIC datapath
    localparam int CORDIC_STAGES = 40;
    localparam int XY_FRAC       = 30;
    localparam int XY_W          = DATA_W + XY_FRAC + 3;
    localparam int Z_FRAC        = 40;
    localparam int Z_W           = 43;
    localparam int PH_W          = Z_W + 1;
    localparam int PH_FRAC       = 13;
    localparam int ROUND_SHIFT   = Z_FRAC - PH_FRAC;

    // output ranges
    localparam logic [MAG_W-1:0]          MAG_MAX   = MAG_W'(46341);
    localparam logic signed [PHASE_W-1:0] PHASE_MAX = PHASE_W'(25736);

    // arctangent series, Q60
    localparam logic [63:0]  ONE_Q60  = 64'd1 << 60;
    localparam int unsigned  MACHIN_A = 5;
    localparam int unsigned  MACHIN_B = 239;

    typedef struct packed {
        logic re_zero;
        logic re_neg;
        logic im_zero;
        logic im_neg;
        logic last;
    } r2p_flags_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
        r2p_flags_t             flags;
    } r2p_pipe_t;

    typedef struct packed {
        logic [MAG_W-1:0]          magnitude;
        logic signed [PHASE_W-1:0] phase;
        logic                      last;
    } r2p_result_t;

    // restoring long division for the constant angle tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-k) in Q60 by the alternating series
    function automatic logic signed [63:0] atan_pow2_q60(input int unsigned k);
        logic [63:0]        t;
        logic [63:0]        odd;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 j;
        t   = ONE_Q60 >> k;
        odd = 64'd1;
        sum = '0;
        for (j = 0; j < 64; j++) begin
            if (t != 64'd0) begin
                term = udiv64(t, odd);
                if (j[0] == 1'b0) sum = sum + $signed(term);
                else              sum = sum - $signed(term);
                t   = t >> (2 * k);
                odd = odd + 64'd2;
            end
        end
        return sum;
    endfunction

    // atan(1/5) or atan(1/239) in Q60
    function automatic logic signed [63:0] atan_machin_q60(input bit use_b);
        logic [63:0]        t;
        logic [63:0]        odd;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [63:0] sum;
        int                 j;
        n   = use_b ? 64'(MACHIN_B) : 64'(MACHIN_A);
        t   = udiv64(ONE_Q60, n);
        odd = 64'd1;
        sum = '0;
        for (j = 0; j < 64; j++) begin
            if (t != 64'd0) begin
                term = udiv64(t, odd);
                if (j[0] == 1'b0) sum = sum + $signed(term);
                else              sum = sum - $signed(term);
                t   = udiv64(udiv64(t, n), n);
                odd = odd + 64'd2;
            end
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] quarter_pi_q60();
        return 64'sd4 * atan_machin_q60(1'b0) - atan_machin_q60(1'b1);
    endfunction

    function automatic logic signed [63:0] q60_to_q40(input logic signed [63:0] v);
        return $signed((v + 64'sd524288) >>> 20);
    endfunction

    function automatic logic signed [63:0] atan_tab_q40(input int unsigned i);
        if (i == 0) return q60_to_q40(quarter_pi_q60());
        return q60_to_q40(atan_pow2_q60(i));
    endfunction

    localparam logic signed [PH_W-1:0] PI_Q40 =
        PH_W'(q60_to_q40(64'sd4 * quarter_pi_q60()));
    localparam logic signed [PH_W-1:0] HALF_PI_Q40 =
        PH_W'(q60_to_q40(64'sd2 * quarter_pi_q60()));

endpackage

// ----- rtl/r2p_front.sv -----
module r2p_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic signed [r2p_pkg::DATA_W-1:0]   real_part,
    input  logic signed [r2p_pkg::DATA_W-1:0]   imag_part,
    input  logic                                block_end,
    output logic                                out_valid,
    output r2p_pkg::r2p_pipe_t                  out_data
);
    import r2p_pkg::*;

    localparam int EFF_W = (SAMPLE_WIDTH > DATA_W) ? DATA_W : SAMPLE_WIDTH;
    localparam int SHIFT = DATA_W - EFF_W;

    logic signed [DATA_W-1:0] re_sh, im_sh, re_se, im_se;
    logic [DATA_W-1:0]        re_u, im_u, re_abs, im_abs;
    r2p_flags_t               flags_next;

    // stage A: sign extension, absolute values, squares
    logic                     a_valid_reg;
    logic [DATA_W-1:0]        re_abs_reg, im_abs_reg;
    logic [SQ2_W-1:0]         re_sq_reg, im_sq_reg;
    r2p_flags_t               a_flags_reg;

    // stage B: CORDIC start vector, sum of squares
    logic                     b_valid_reg;
    r2p_pipe_t                b_data_reg, b_data_next;

    assign re_sh = real_part <<< SHIFT;
    assign im_sh = imag_part <<< SHIFT;
    assign re_se = re_sh >>> SHIFT;
    assign im_se = im_sh >>> SHIFT;
    assign re_u  = re_se;
    assign im_u  = im_se;

    assign re_abs = re_se[DATA_W-1] ? (~re_u + 1'b1) : re_u;
    assign im_abs = im_se[DATA_W-1] ? (~im_u + 1'b1) : im_u;

    always_comb
    begin
        flags_next.re_zero = (re_u == '0);
        flags_next.re_neg  = re_se[DATA_W-1];
        flags_next.im_zero = (im_u == '0);
        flags_next.im_neg  = im_se[DATA_W-1];
        flags_next.last    = block_end;
    end

    always_comb
    begin
        b_data_next.x     = $signed({{(XY_W-DATA_W-XY_FRAC){1'b0}}, re_abs_reg,
                                     {XY_FRAC{1'b0}}});
        b_data_next.y     = $signed({{(XY_W-DATA_W-XY_FRAC){1'b0}}, im_abs_reg,
                                     {XY_FRAC{1'b0}}});
        b_data_next.z     = '0;
        b_data_next.rem   = SQ_W'(re_sq_reg) + SQ_W'(im_sq_reg);
        b_data_next.root  = '0;
        b_data_next.flags = a_flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            re_abs_reg  <= re_abs;
            im_abs_reg  <= im_abs;
            re_sq_reg   <= SQ2_W'(re_abs) * SQ2_W'(re_abs);
            im_sq_reg   <= SQ2_W'(im_abs) * SQ2_W'(im_abs);
            a_flags_reg <= flags_next;
            b_data_reg  <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ----- rtl/r2p_stage.sv -----
module r2p_stage #(
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_valid,
    input  r2p_pkg::r2p_pipe_t   in_data,
    output logic                 out_valid,
    output r2p_pkg::r2p_pipe_t   out_data
);
    import r2p_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_tab_q40(IDX));

    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]  z_in;
    logic [SQ_W-1:0]        rem_next, root_next;

    logic                   valid_reg;
    r2p_pipe_t              data_reg, data_next;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign z_in = in_data.z;
    assign dx   = y_in >>> IDX;
    assign dy   = x_in >>> IDX;

    // one root digit per stage while digits remain
    generate
        if (IDX < ROOT_STEPS)
        begin : g_root
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - IDX));
            logic [SQ_W-1:0] trial;
            assign trial = in_data.root + BIT;
            always_comb
            begin
                if (in_data.rem >= trial)
                begin
                    rem_next  = in_data.rem - trial;
                    root_next = (in_data.root >> 1) + BIT;
                end
                else
                begin
                    rem_next  = in_data.rem;
                    root_next = in_data.root >> 1;
                end
            end
        end
        else
        begin : g_pass
            assign rem_next  = in_data.rem;
            assign root_next = in_data.root;
        end
    endgenerate

    always_comb
    begin
        data_next.rem   = rem_next;
        data_next.root  = root_next;
        data_next.flags = in_data.flags;
        if (!y_in[XY_W-1])
        begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + ANG;
        end
        else
        begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ce)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/r2p_back.sv -----
module r2p_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  logic                   in_valid,
    input  r2p_pkg::r2p_pipe_t     in_data,
    output logic                   out_valid,
    output r2p_pkg::r2p_result_t   out_data
);
    import r2p_pkg::*;

    localparam logic signed [PH_W-1:0] ROUND_HALF = PH_W'(1) <<< (ROUND_SHIFT - 1);

    logic signed [PH_W-1:0] z_ext, zc_next, rounded;
    logic [MAG_W-1:0]       mag_next;
    r2p_flags_t             fl;

    // stage C: quadrant fix-up, magnitude rounding
    logic                   c_valid_reg;
    logic signed [PH_W-1:0] zc_reg;
    logic [MAG_W-1:0]       c_mag_reg;
    logic                   c_last_reg;

    // stage D: phase rounding to Q2.13
    logic                   d_valid_reg;
    r2p_result_t            d_data_reg, d_data_next;

    assign fl    = in_data.flags;
    assign z_ext = PH_W'(in_data.z);

    always_comb
    begin
        if (fl.re_zero)
        begin
            if (fl.im_zero)     zc_next = '0;
            else if (fl.im_neg) zc_next = -HALF_PI_Q40;
            else                zc_next = HALF_PI_Q40;
        end
        else if (!fl.re_neg)
            zc_next = fl.im_neg ? -z_ext : z_ext;
        else
            zc_next = fl.im_neg ? (z_ext - PI_Q40) : (PI_Q40 - z_ext);
    end

    assign mag_next = in_data.root[MAG_W-1:0] + MAG_W'(in_data.rem > in_data.root);

    assign rounded = (zc_reg + ROUND_HALF) >>> ROUND_SHIFT;

    always_comb
    begin
        d_data_next.magnitude = c_mag_reg;
        d_data_next.phase     = rounded[PHASE_W-1:0];
        d_data_next.last      = c_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zc_reg     <= zc_next;
            c_mag_reg  <= mag_next;
            c_last_reg <= fl.last;
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

// ----- rtl/rectangular_to_polar.sv -----
// Channel   Dir  Bits  Contents
// s_*       in   32+1  tdata: real_part[15:0], imag_part[31:16]; tlast: block_end
// m_*       out  32+1  tdata: magnitude[15:0], phase[31:16]; tlast: block_end_out
//
// One sample per cycle sustained while the output is not stalled; m_tvalid rises
// once the input transfer has passed 45 registers (2 front stages, 40 CORDIC stages
// at one rotation each, 2 back stages, output reg).
// Throughput is set by the single shared clock enable on the stage chain.
// Reset clears every valid bit at once; no clearing pass, no tables in RAM.
// A stalled output parks one result in a skid register; the chain then freezes
// and s_tready drops until the skid drains. Nothing is dropped or repeated.
`include "assert_macros.svh"

module rectangular_to_polar #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [r2p_pkg::S_TDATA_W-1:0]       s_tdata,   // real_part, imag_part
    input  logic                                s_tlast,   // block_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [r2p_pkg::M_TDATA_W-1:0]       m_tdata,   // magnitude, phase
    output logic                                m_tlast    // block_end_out
);
    import r2p_pkg::*;

    logic                     pipe_ce;
    logic signed [DATA_W-1:0] real_part, imag_part;

    // stage chain: index 0 is the front output, index k+1 follows CORDIC stage k
    logic                     chain_valid [CORDIC_STAGES+1];
    r2p_pipe_t                chain_data  [CORDIC_STAGES+1];

    logic                     tail_valid;
    r2p_result_t              tail_data;

    // output register and skid register
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    r2p_result_t              out_data_reg, skid_data_reg, out_load_data;
    logic                     out_load, skid_load;

    // chain advances whenever the skid has room
    assign pipe_ce  = !skid_valid_reg;
    assign s_tready = pipe_ce;

    assign real_part = $signed(s_tdata[DATA_W-1:0]);
    assign imag_part = $signed(s_tdata[S_TDATA_W-1:DATA_W]);

    r2p_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (pipe_ce),
        .in_valid  (s_tvalid),
        .real_part (real_part),
        .imag_part (imag_part),
        .block_end (s_tlast),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    generate
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            r2p_stage #(
                .IDX (i)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .ce        (pipe_ce),
                .in_valid  (chain_valid[i]),
                .in_data   (chain_data[i]),
                .out_valid (chain_valid[i+1]),
                .out_data  (chain_data[i+1])
            );
        end
    endgenerate

    r2p_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (pipe_ce),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (tail_valid),
        .out_data  (tail_data)
    );

    // Output side. With the skid full the chain is frozen and only the skid
    // can move. Otherwise the tail result goes to the output register when it
    // is free or being drained, else into the skid.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_load_data   = tail_data;
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_load        = 1'b1;
                out_load_data   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_next = tail_valid;
            out_load       = tail_valid;
        end
        else if (tail_valid)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_load_data;
        if (skid_load)
            skid_data_reg <= tail_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.phase, out_data_reg.magnitude};
    assign m_tlast  = out_data_reg.last;

    // skid only ever holds data behind a full output register
    `ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
                   "skid full, output empty")
    // skid fills only on a cycle where the output was stalled
    `ASSERT_RST(a_skid_fill_on_stall,
                $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready),
                "skid filled without stall")
    // a frozen chain holds its tail
    `ASSERT_RST(a_chain_frozen, !pipe_ce |=> $stable(tail_valid), "tail moved while frozen")
    // results stay within the documented ranges
    `ASSERT_RST(a_result_range,
                out_valid_reg |-> (out_data_reg.magnitude <= MAG_MAX)
                    && ($signed(out_data_reg.phase) <= PHASE_MAX)
                    && ($signed(out_data_reg.phase) >= -PHASE_MAX),
                "result out of range")

endmodule
